FILE: design/twec_pkg.sv
`timescale 1ns / 1ps

package twec_pkg;

   localparam int MAX_CLUSTERS = 16;
   localparam int MAX_MEMBERS  = 32;
   localparam int MODULE_BITS  = 12;

   localparam int CL_BITS     = $clog2(MAX_CLUSTERS);
   localparam int TOTAL_BITS  = CL_BITS + 1;
   localparam int MEM_BITS    = $clog2(MAX_MEMBERS);
   localparam int SIZE_BITS   = MEM_BITS + 1;
   localparam int MADDR_BITS  = CL_BITS + MEM_BITS;

   localparam int TIME_BITS    = 32;
   localparam int WINDOW_BITS  = 16;
   localparam int ID_BITS      = 12;
   localparam int OUT_IDX_BITS = 4;
   localparam int OUT_CNT_BITS = 6;
   localparam int OUTCOME_BITS = 3;

   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 16'd1600;

   typedef enum logic [OUTCOME_BITS-1:0] {
      OUT_JOINED     = 3'd0,
      OUT_NEW        = 3'd1,
      OUT_DUPLICATE  = 3'd2,
      OUT_NO_CLUSTER = 3'd3,
      OUT_FULL       = 3'd4
   } outcome_type;

endpackage

FILE: design/twec_ram.sv
`timescale 1ns / 1ps

module twec_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/time_window_event_clusterer_top.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// req_      in         req_valid / req_stall     event_time, module_id, batch_start
// rsp_      out        rsp_valid / rsp_stall     cluster_index, outcome, member_count
// csr_      in         csr_valid / csr_ready     time_window
//
// An item scans the open clusters until one lies within the window, then the members
// of the matched cluster until a duplicate is found: one read per cycle from the cluster
// table, then one per cycle from the member memory, both through registered synchronous reads.
// One item is in work at a time.
// Reset is synchronous and active high; it closes all clusters and reloads the window.
// A stalled result waits in the output register; the next item is accepted meanwhile.

module time_window_event_clusterer_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [twec_pkg::TIME_BITS-1:0]      req_event_time,
   input  logic [twec_pkg::ID_BITS-1:0]        req_module_id,
   input  logic                                req_batch_start,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [twec_pkg::OUT_IDX_BITS-1:0]   rsp_cluster_index,
   output logic [twec_pkg::OUTCOME_BITS-1:0]   rsp_outcome,
   output logic [twec_pkg::OUT_CNT_BITS-1:0]   rsp_member_count,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [twec_pkg::WINDOW_BITS-1:0]    csr_time_window
);

   import twec_pkg::*;

   localparam int CWIDTH = TIME_BITS + SIZE_BITS;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CSCAN = 4'b0010,
      ST_MSCAN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type                state_ff, state_in;
   logic [WINDOW_BITS-1:0]   window_ff, window_in;
   logic [TOTAL_BITS-1:0]    total_ff, total_in;
   logic [TIME_BITS-1:0]     ev_time_ff, ev_time_in;
   logic [MODULE_BITS-1:0]   ev_mod_ff, ev_mod_in;
   logic [TOTAL_BITS-1:0]    cl_cnt_ff, cl_cnt_in;
   logic [SIZE_BITS-1:0]     mb_cnt_ff, mb_cnt_in;
   logic                     pend_ff, pend_in;
   logic                     pend_last_ff, pend_last_in;
   logic [CL_BITS-1:0]       pend_addr_ff, pend_addr_in;
   logic [CL_BITS-1:0]       hit_c_ff, hit_c_in;
   logic [SIZE_BITS-1:0]     hit_size_ff, hit_size_in;
   outcome_type              res_outcome_ff, res_outcome_in;
   logic [OUT_IDX_BITS-1:0]  res_idx_ff, res_idx_in;
   logic [OUT_CNT_BITS-1:0]  res_cnt_ff, res_cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [OUT_IDX_BITS-1:0]  rsp_idx_ff, rsp_idx_in;
   outcome_type              rsp_outcome_ff, rsp_outcome_in;
   logic [OUT_CNT_BITS-1:0]  rsp_cnt_ff, rsp_cnt_in;

   logic                     c_wr_en;
   logic [CL_BITS-1:0]       c_wr_addr;
   logic [CWIDTH-1:0]        c_wr_data;
   logic [CWIDTH-1:0]        c_rd_data;
   logic                     m_wr_en;
   logic [MADDR_BITS-1:0]    m_wr_addr;
   logic [MODULE_BITS-1:0]   m_wr_data;
   logic [MODULE_BITS-1:0]   m_rd_data;

   logic [TIME_BITS-1:0]     rd_time;
   logic [SIZE_BITS-1:0]     rd_size;
   logic [TIME_BITS-1:0]     time_dist;
   logic                     time_hit;
   logic                     c_issue;
   logic                     m_issue;
   logic [SIZE_BITS-1:0]     scan_len;
   logic                     out_free;

   assign rd_time   = c_rd_data[CWIDTH-1 -: TIME_BITS];
   assign rd_size   = c_rd_data[SIZE_BITS-1:0];
   assign time_dist = (ev_time_ff >= rd_time) ? (ev_time_ff - rd_time)
                                              : (rd_time - ev_time_ff);
   assign time_hit  = time_dist <= {{(TIME_BITS-WINDOW_BITS){1'b0}}, window_ff};

   assign c_issue  = cl_cnt_ff < total_ff;
   assign scan_len = (hit_size_ff > SIZE_BITS'(MAX_MEMBERS)) ? SIZE_BITS'(MAX_MEMBERS)
                                                             : hit_size_ff;
   assign m_issue  = mb_cnt_ff < scan_len;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   twec_ram #(.WIDTH(CWIDTH), .DEPTH(MAX_CLUSTERS)) u_cluster_ram (
      .clock   (clock),
      .wr_en   (c_wr_en),
      .wr_addr (c_wr_addr),
      .wr_data (c_wr_data),
      .rd_addr (cl_cnt_ff[CL_BITS-1:0]),
      .rd_data (c_rd_data)
   );

   twec_ram #(.WIDTH(MODULE_BITS), .DEPTH(MAX_CLUSTERS * MAX_MEMBERS)) u_member_ram (
      .clock   (clock),
      .wr_en   (m_wr_en),
      .wr_addr (m_wr_addr),
      .wr_data (m_wr_data),
      .rd_addr ({hit_c_ff, mb_cnt_ff[MEM_BITS-1:0]}),
      .rd_data (m_rd_data)
   );

   always_comb begin
      state_in       = state_ff;
      window_in      = window_ff;
      total_in       = total_ff;
      ev_time_in     = ev_time_ff;
      ev_mod_in      = ev_mod_ff;
      cl_cnt_in      = cl_cnt_ff;
      mb_cnt_in      = mb_cnt_ff;
      pend_in        = pend_ff;
      pend_last_in   = pend_last_ff;
      pend_addr_in   = pend_addr_ff;
      hit_c_in       = hit_c_ff;
      hit_size_in    = hit_size_ff;
      res_outcome_in = res_outcome_ff;
      res_idx_in     = res_idx_ff;
      res_cnt_in     = res_cnt_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_idx_in     = rsp_idx_ff;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_cnt_in     = rsp_cnt_ff;
      c_wr_en        = 1'b0;
      c_wr_addr      = hit_c_ff;
      c_wr_data      = {ev_time_ff, hit_size_ff + SIZE_BITS'(1)};
      m_wr_en        = 1'b0;
      m_wr_addr      = {hit_c_ff, hit_size_ff[MEM_BITS-1:0]};
      m_wr_data      = ev_mod_ff;

      if (csr_valid) begin
         window_in = csr_time_window;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ev_time_in = req_event_time;
               ev_mod_in  = MODULE_BITS'(req_module_id);
               if (req_batch_start) begin
                  total_in = '0;
               end
               cl_cnt_in = '0;
               pend_in   = 1'b0;
               state_in  = ST_CSCAN;
            end
         end

         ST_CSCAN: begin
            // Each read is issued in the cycle before the compare on the returned tail time.
            pend_in      = c_issue;
            pend_last_in = (cl_cnt_ff + TOTAL_BITS'(1)) == total_ff;
            pend_addr_in = cl_cnt_ff[CL_BITS-1:0];
            if (c_issue) begin
               cl_cnt_in = cl_cnt_ff + TOTAL_BITS'(1);
            end
            if (pend_ff && time_hit) begin
               hit_c_in    = pend_addr_ff;
               hit_size_in = rd_size;
               mb_cnt_in   = '0;
               pend_in     = 1'b0;
               state_in    = ST_MSCAN;
            end else if ((pend_ff && pend_last_ff) || (!pend_ff && !c_issue)) begin
               if (total_ff >= TOTAL_BITS'(MAX_CLUSTERS)) begin
                  res_outcome_in = OUT_NO_CLUSTER;
                  res_idx_in     = '0;
                  res_cnt_in     = '0;
               end else begin
                  res_outcome_in = OUT_NEW;
                  res_idx_in     = OUT_IDX_BITS'(total_ff);
                  res_cnt_in     = OUT_CNT_BITS'(1);
               end
               state_in = ST_DONE;
            end
         end

         ST_MSCAN: begin
            pend_in      = m_issue;
            pend_last_in = (mb_cnt_ff + SIZE_BITS'(1)) == scan_len;
            if (m_issue) begin
               mb_cnt_in = mb_cnt_ff + SIZE_BITS'(1);
            end
            res_idx_in = OUT_IDX_BITS'(hit_c_ff);
            if (pend_ff && (m_rd_data == ev_mod_ff)) begin
               res_outcome_in = OUT_DUPLICATE;
               res_cnt_in     = OUT_CNT_BITS'(hit_size_ff);
               state_in       = ST_DONE;
            end else if ((pend_ff && pend_last_ff) || (!pend_ff && !m_issue)) begin
               if (hit_size_ff >= SIZE_BITS'(MAX_MEMBERS)) begin
                  res_outcome_in = OUT_FULL;
                  res_cnt_in     = OUT_CNT_BITS'(hit_size_ff);
               end else begin
                  res_outcome_in = OUT_JOINED;
                  res_cnt_in     = OUT_CNT_BITS'(hit_size_ff + SIZE_BITS'(1));
               end
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_idx_in     = res_idx_ff;
               rsp_outcome_in = res_outcome_ff;
               rsp_cnt_in     = res_cnt_ff;
               state_in       = ST_IDLE;
               case (res_outcome_ff)
                  OUT_NEW: begin
                     c_wr_en   = 1'b1;
                     c_wr_addr = total_ff[CL_BITS-1:0];
                     c_wr_data = {ev_time_ff, SIZE_BITS'(1)};
                     m_wr_en   = 1'b1;
                     m_wr_addr = {total_ff[CL_BITS-1:0], {MEM_BITS{1'b0}}};
                     total_in  = total_ff + TOTAL_BITS'(1);
                  end
                  OUT_JOINED: begin
                     c_wr_en = 1'b1;
                     m_wr_en = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= WINDOW_RESET;
         total_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         total_ff     <= total_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_time_ff     <= ev_time_in;
      ev_mod_ff      <= ev_mod_in;
      cl_cnt_ff      <= cl_cnt_in;
      mb_cnt_ff      <= mb_cnt_in;
      pend_last_ff   <= pend_last_in;
      pend_addr_ff   <= pend_addr_in;
      hit_c_ff       <= hit_c_in;
      hit_size_ff    <= hit_size_in;
      res_outcome_ff <= res_outcome_in;
      res_idx_ff     <= res_idx_in;
      res_cnt_ff     <= res_cnt_in;
      rsp_idx_ff     <= rsp_idx_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_cnt_ff     <= rsp_cnt_in;
   end

   assign req_stall         = state_ff != ST_IDLE;
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cluster_index = rsp_idx_ff;
   assign rsp_outcome       = rsp_outcome_ff;
   assign rsp_member_count  = rsp_cnt_ff;

endmodule

FILE: design/twec_checker.sv
`timescale 1ns / 1ps

module twec_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic [twec_pkg::TIME_BITS-1:0]      req_event_time,
   input logic [twec_pkg::ID_BITS-1:0]        req_module_id,
   input logic                                req_batch_start,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [twec_pkg::OUT_IDX_BITS-1:0]   rsp_cluster_index,
   input logic [twec_pkg::OUTCOME_BITS-1:0]   rsp_outcome,
   input logic [twec_pkg::OUT_CNT_BITS-1:0]   rsp_member_count,
   input logic                                csr_valid,
   input logic                                csr_ready,
   input logic [twec_pkg::WINDOW_BITS-1:0]    csr_time_window
);

   import twec_pkg::*;

   // An item in work blocks the next one until its result is registered.
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken while an item is in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_outcome)
         && $stable(rsp_cluster_index) && $stable(rsp_member_count)))
      else $error("stalled result changed");

   a_new_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_outcome == OUT_NEW) |-> rsp_member_count == OUT_CNT_BITS'(1))
      else $error("new cluster without exactly one member");

   a_no_cluster: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_outcome == OUT_NO_CLUSTER)
         |-> (rsp_cluster_index == '0 && rsp_member_count == '0))
      else $error("refused item reports a cluster");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_outcome == OUT_FULL)
         |-> rsp_member_count == OUT_CNT_BITS'(MAX_MEMBERS))
      else $error("full cluster with wrong member count");

endmodule

bind time_window_event_clusterer_top twec_checker u_twec_checker (.*);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   import twec_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 60;

   typedef struct {
      logic [OUT_IDX_BITS-1:0] index;
      outcome_type             outcome;
      logic [OUT_CNT_BITS-1:0] count;
   } cluster_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [TIME_BITS-1:0]    req_event_time = '0;
   logic [ID_BITS-1:0]      req_module_id = '0;
   logic                    req_batch_start = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [OUT_IDX_BITS-1:0] rsp_cluster_index;
   logic [OUTCOME_BITS-1:0] rsp_outcome;
   logic [OUT_CNT_BITS-1:0] rsp_member_count;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [WINDOW_BITS-1:0]  csr_time_window = '0;

   // Shadow copy of the clusterer state.
   logic [WINDOW_BITS-1:0] window_setting;
   int                     open_clusters;
   logic [TIME_BITS-1:0]   tail_time [MAX_CLUSTERS];
   int                     cluster_fill [MAX_CLUSTERS];
   logic [ID_BITS-1:0]     member_ids [MAX_CLUSTERS][MAX_MEMBERS];

   cluster_result_type pending_results [$];
   cluster_result_type oldest;
   int                 mismatches = 0;
   int                 cycle_count = 0;
   int                 send_burst = 0;
   int                 stall_run = 0;
   bit                 stall_now = 1'b0;

   time_window_event_clusterer_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_event_time    (req_event_time),
      .req_module_id     (req_module_id),
      .req_batch_start   (req_batch_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cluster_index (rsp_cluster_index),
      .rsp_outcome       (rsp_outcome),
      .rsp_member_count  (rsp_member_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_time_window   (csr_time_window)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic cluster_result_type predict_cluster(input logic [TIME_BITS-1:0] t,
                                                          input logic [ID_BITS-1:0] id,
                                                          input logic batch);
      cluster_result_type   r;
      logic [ID_BITS-1:0]   key;
      logic [TIME_BITS-1:0] span;
      int                   hit;
      bit                   dup;
      key = id & ID_BITS'((1 << MODULE_BITS) - 1);
      r.index = '0;
      r.count = '0;
      hit = -1;
      dup = 1'b0;
      if (batch)
         open_clusters = 0;
      for (int c = 0; c < open_clusters; c++) begin
         if (hit < 0) begin
            span = (t >= tail_time[c]) ? t - tail_time[c] : tail_time[c] - t;
            if (span <= TIME_BITS'(window_setting))
               hit = c;
         end
      end
      if (hit >= 0) begin
         for (int k = 0; k < cluster_fill[hit]; k++)
            if (member_ids[hit][k] == key)
               dup = 1'b1;
         if (dup) begin
            r.outcome = OUT_DUPLICATE;
         end else if (cluster_fill[hit] >= MAX_MEMBERS) begin
            r.outcome = OUT_FULL;
         end else begin
            member_ids[hit][cluster_fill[hit]] = key;
            cluster_fill[hit]++;
            tail_time[hit] = t;
            r.outcome = OUT_JOINED;
         end
         r.index = OUT_IDX_BITS'(hit);
         r.count = OUT_CNT_BITS'(cluster_fill[hit]);
      end else if (open_clusters >= MAX_CLUSTERS) begin
         r.outcome = OUT_NO_CLUSTER;
      end else begin
         tail_time[open_clusters] = t;
         cluster_fill[open_clusters] = 1;
         member_ids[open_clusters][0] = key;
         r.index = OUT_IDX_BITS'(open_clusters);
         r.count = OUT_CNT_BITS'(1);
         r.outcome = OUT_NEW;
         open_clusters++;
      end
      return r;
   endfunction

   // Mostly short gaps, a few long ones, and now and then a burst with none at all.
   function automatic int pick_gap();
      int r;
      if (send_burst > 0) begin
         send_burst--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         send_burst = $urandom_range(10, 40);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH cycle %0d: %s", cycle_count, what);
      mismatches++;
   endtask

   task automatic send_event(input logic [TIME_BITS-1:0] t, input logic [ID_BITS-1:0] id,
                             input logic batch);
      int                 gap;
      cluster_result_type expected;
      req_event_time  <= t;
      req_module_id   <= id;
      req_batch_start <= batch;
      req_valid       <= 1'b1;
      do @(posedge clock); while (req_stall);
      expected = predict_cluster(t, id, batch);
      pending_results.insert(pending_results.size(), expected);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_window(input logic [WINDOW_BITS-1:0] value);
      wait_idle();
      csr_time_window <= value;
      csr_valid       <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      window_setting = value;
   endtask

   // Runs on the reset window first, then on the two extreme windows.
   task automatic test_window_edges();
      send_event(32'd1000, 12'd0, 1'b1);
      send_event(32'd2600, 12'd1, 1'b0);
      send_event(32'd4201, 12'd2, 1'b0);
      send_event(32'd4201, 12'd1, 1'b0);
      send_event(32'd2600, 12'd1, 1'b0);
      send_event(32'd1000, 12'hFFF, 1'b0);
      send_event(32'hFFFF_FFFF, 12'hFFF, 1'b0);
      send_event(32'd0, 12'hFFF, 1'b0);
      send_event(32'hFFFF_FFFF, 12'hAAA, 1'b1);
      send_event(32'hFFFF_F9C0, 12'h555, 1'b0);
      write_window(16'd0);
      send_event(32'd5, 12'd7, 1'b1);
      send_event(32'd5, 12'd8, 1'b0);
      send_event(32'd6, 12'd9, 1'b0);
      send_event(32'd4, 12'd3, 1'b0);
      send_event(32'd5, 12'd7, 1'b0);
      write_window(16'hFFFF);
      send_event(32'd0, 12'd0, 1'b1);
      send_event(32'd65535, 12'd1, 1'b0);
      send_event(32'd131071, 12'd2, 1'b0);
      send_event(32'd131070, 12'd2, 1'b0);
   endtask

   // Fills one cluster to its limit, then offers it new and repeated modules.
   task automatic test_cluster_full();
      logic [TIME_BITS-1:0] t;
      logic [ID_BITS-1:0]   base_id;
      write_window(16'd100);
      t = $urandom_range(0, 32'h7FFF_FFFF);
      base_id = 12'($urandom);
      send_event(t, base_id, 1'b1);
      for (int k = 1; k < MAX_MEMBERS + 8; k++) begin
         t = t + $urandom_range(0, 3);
         if (k == 10)
            send_event(t, base_id + 12'd3, 1'b0);
         send_event(t, base_id + ID_BITS'(k), 1'b0);
      end
      send_event(t, base_id + 12'd5, 1'b0);
   endtask

   // Opens every cluster, then sends events that fit none and some that fit one.
   task automatic test_table_full();
      logic [TIME_BITS-1:0] t;
      logic [TIME_BITS-1:0] opened [MAX_CLUSTERS + 2];
      write_window(16'd10);
      t = $urandom_range(0, 32'h7FFF_FFFF);
      for (int k = 0; k < MAX_CLUSTERS + 2; k++) begin
         opened[k] = t;
         send_event(t, 12'($urandom), k == 0);
         t = t + $urandom_range(11, 5000);
      end
      for (int k = 0; k < 3; k++)
         send_event(opened[$urandom_range(0, MAX_CLUSTERS - 1)], 12'($urandom), 1'b0);
   endtask

   // Batches of events that wander around a running time, with module ids drawn
   // partly from a small set so that duplicates show up, and some pure noise.
   task automatic test_random_batches(input int item_goal);
      int                   sent;
      int                   run_len;
      int                   r;
      int                   w;
      logic [TIME_BITS-1:0] t;
      logic [ID_BITS-1:0]   id_set [8];
      logic [ID_BITS-1:0]   id;
      logic                 batch;
      sent = 0;
      t = $urandom;
      while (sent < item_goal) begin
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 5))
               0: write_window(16'd0);
               1: write_window(16'hFFFF);
               2: write_window(WINDOW_RESET);
               3, 4: write_window(WINDOW_BITS'($urandom_range(1, 300)));
               default: write_window(WINDOW_BITS'($urandom));
            endcase
         end
         w = window_setting;
         foreach (id_set[i])
            id_set[i] = ID_BITS'($urandom);
         if ($urandom_range(0, 9) == 0)
            t = $urandom;
         run_len = $urandom_range(1, 80);
         for (int k = 0; k < run_len; k++) begin
            r = $urandom_range(0, 99);
            batch = (k == 0);
            id = $urandom_range(0, 1) ? id_set[$urandom_range(0, 7)] : ID_BITS'($urandom);
            if (r < 5) begin
               t = $urandom;
               id = ID_BITS'($urandom);
               batch = 1'($urandom);
            end else if (r < 75) begin
               t = t + $urandom_range(0, 2 * w + 2) - w - 1;
            end else begin
               t = t + $urandom_range(w + 1, 4 * w + 8);
            end
            send_event(t, id, batch);
            sent++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (stall_run == 0) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin stall_now = 1'b0; stall_run = $urandom_range(0, 4); end
            5: begin stall_now = 1'b0; stall_run = $urandom_range(20, 80); end
            6, 7, 8: begin stall_now = 1'b1; stall_run = $urandom_range(0, 3); end
            default: begin stall_now = 1'b1; stall_run = $urandom_range(8, 50); end
         endcase
      end else begin
         stall_run--;
      end
      rsp_stall <= stall_now;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result arrived with no event outstanding");
         end else begin
            oldest = pending_results.pop_front();
            if (rsp_cluster_index !== oldest.index)
               report_mismatch($sformatf("cluster_index %0d, expected %0d",
                                         rsp_cluster_index, oldest.index));
            if (rsp_outcome !== oldest.outcome)
               report_mismatch($sformatf("outcome %0d, expected %0d",
                                         rsp_outcome, oldest.outcome));
            if (rsp_member_count !== oldest.count)
               report_mismatch($sformatf("member_count %0d, expected %0d",
                                         rsp_member_count, oldest.count));
         end
      end
   end

   initial begin
      window_setting = WINDOW_RESET;
      open_clusters = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_window_edges();
      test_cluster_full();
      test_table_full();
      test_random_batches(800);
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
